@@ hdl/lmst_pkg.sv @@
package lmst_pkg;

   localparam int MATRIX_COLUMNS = 8;
   localparam int COL_W = 3;
   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 4;
   localparam int RSP_LEVEL_W = 3;
   localparam logic [7:0] TEXT_WIDTH_RESET = 8'd8;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef struct packed {
      logic       cmd;
      logic [7:0] column_index;
      logic [7:0] column_bits;
   } req_type;

   typedef struct packed {
      logic [3:0] reg_address;
      logic [7:0] reg_data;
      logic       last;
   } rsp_type;

endpackage

@@ hdl/lmst_fifo.sv @@
module lmst_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   output logic                       full,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] level
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [AW-1:0]    head_ff, head_in;
   logic [AW-1:0]    tail_ff, tail_in;
   logic [LW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == LW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign level    = count_ff;
   assign pop_data = store_ff[head_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in = (tail_ff == AW'(DEPTH-1)) ? '0 : tail_ff + 1'b1;
      end
      if (do_pop) begin
         head_in = (head_ff == AW'(DEPTH-1)) ? '0 : head_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[tail_ff] <= push_data;
      end
   end

endmodule

@@ hdl/lmst_engine.sv @@
module lmst_engine #(
   parameter int TEXT_COLUMNS = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [7:0]                          csr_write_data,
   input  logic                                cmd_empty,
   input  lmst_pkg::req_type                   cmd_item,
   output logic                                cmd_pop,
   input  logic [lmst_pkg::RSP_LEVEL_W-1:0]    rsp_level,
   output logic                                rsp_push,
   output lmst_pkg::rsp_type                   rsp_item
);
   import lmst_pkg::*;

   localparam int AW = (TEXT_COLUMNS > 1) ? $clog2(TEXT_COLUMNS) : 1;

   typedef enum logic {ST_IDLE, ST_SCAN} state_type;

   state_type         state_ff, state_in;
   logic [7:0]        text_width_ff;
   logic [7:0]        start_ff, start_in;
   logic [7:0]        vis_ff, vis_in;
   logic [7:0]        lead_ff, lead_in;
   logic [COL_W-1:0]  x_ff, x_in;
   logic [COL_W-1:0]  rd_x_ff, rd_x_in;
   logic              rd_pend_ff, rd_pend_in;
   logic              rd_hit_ff, rd_hit_in;
   logic [TEXT_COLUMNS-1:0] valid_ff;
   logic [7:0]        text_mem_ff [TEXT_COLUMNS];
   logic [7:0]        rd_data_ff;

   logic [7:0]        adv_start, adv_vis, adv_lead;
   logic [8:0]        limit;
   logic [7:0]        pos;
   logic              in_store, blank, room, issue;
   logic              load_go;
   logic [AW-1:0]     rd_addr, wr_addr;

   // scroll state update for one tick
   always_comb begin
      adv_start = start_ff;
      adv_vis   = vis_ff;
      adv_lead  = lead_ff;
      if (lead_ff != 8'd0) begin
         adv_lead = lead_ff - 8'd1;
         adv_vis  = vis_ff + 8'd1;
      end else begin
         adv_start = start_ff + 8'd1;
      end
      if ({1'b0, adv_start} + 9'(MATRIX_COLUMNS) >= {1'b0, text_width_ff}) begin
         adv_vis = adv_vis - 8'd1;
      end
      if (adv_start == text_width_ff) begin
         adv_start = 8'd0;
         adv_vis   = 8'd0;
         adv_lead  = 8'(MATRIX_COLUMNS);
      end
   end

   // window for the column being read
   assign limit    = {1'b0, vis_ff} + {1'b0, lead_ff};
   assign pos      = start_ff + 8'(x_ff) - lead_ff;
   assign in_store = ({1'b0, pos} < 9'(TEXT_COLUMNS));
   assign blank    = ({6'd0, x_ff} > limit) || ({5'd0, x_ff} < lead_ff);
   assign rd_addr  = pos[AW-1:0];
   assign wr_addr  = cmd_item.column_index[AW-1:0];

   assign room    = ({1'b0, rsp_level} + {{RSP_LEVEL_W{1'b0}}, rd_pend_ff})
                    < (RSP_LEVEL_W+1)'(RSP_DEPTH);
   assign issue   = (state_ff == ST_SCAN) && room;
   assign cmd_pop = (state_ff == ST_IDLE) && !cmd_empty;
   assign load_go = cmd_pop && (cmd_item.cmd == CMD_LOAD) &&
                    ({1'b0, cmd_item.column_index} < 9'(TEXT_COLUMNS));

   always_comb begin
      state_in   = state_ff;
      start_in   = start_ff;
      vis_in     = vis_ff;
      lead_in    = lead_ff;
      x_in       = x_ff;
      rd_x_in    = rd_x_ff;
      rd_pend_in = 1'b0;
      rd_hit_in  = rd_hit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_pop && cmd_item.cmd == CMD_TICK) begin
               start_in = adv_start;
               vis_in   = adv_vis;
               lead_in  = adv_lead;
               x_in     = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               rd_pend_in = 1'b1;
               rd_x_in    = x_ff;
               rd_hit_in  = !blank && in_store && valid_ff[rd_addr];
               x_in       = x_ff + 1'b1;
               if (x_ff == COL_W'(MATRIX_COLUMNS-1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         start_ff   <= 8'd0;
         vis_ff     <= 8'd0;
         lead_ff    <= 8'(MATRIX_COLUMNS);
         x_ff       <= '0;
         rd_x_ff    <= '0;
         rd_pend_ff <= 1'b0;
         rd_hit_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         start_ff   <= start_in;
         vis_ff     <= vis_in;
         lead_ff    <= lead_in;
         x_ff       <= x_in;
         rd_x_ff    <= rd_x_in;
         rd_pend_ff <= rd_pend_in;
         rd_hit_ff  <= rd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_width_ff <= TEXT_WIDTH_RESET;
      end else if (csr_write_enable) begin
         text_width_ff <= csr_write_data;
      end
   end

   // unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (load_go) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load_go) begin
         text_mem_ff[wr_addr] <= cmd_item.column_bits;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= text_mem_ff[rd_addr];
   end

   assign rsp_push             = rd_pend_ff;
   assign rsp_item.reg_address = 4'(MATRIX_COLUMNS) - {1'b0, rd_x_ff};
   assign rsp_item.reg_data    = rd_hit_ff ? rd_data_ff : 8'd0;
   assign rsp_item.last        = (rd_x_ff == COL_W'(MATRIX_COLUMNS-1));

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (rsp_level < RSP_LEVEL_W'(RSP_DEPTH)))
      else $error("result pushed into full queue");

   a_no_pop_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !cmd_pop)
      else $error("item taken during refresh");

   a_lead_bound: assert property (@(posedge clock) disable iff (reset)
      lead_ff <= 8'(MATRIX_COLUMNS))
      else $error("lead offset out of range");

   a_last_ends_scan: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp_item.last) |-> (state_ff == ST_IDLE || x_ff == '0))
      else $error("refresh continues past last write");

endmodule

@@ hdl/led_matrix_scroll_text.sv @@
// channel   ports                              direction  item
// req       req_push, req_full, req_data       in         load column / scroll tick
// rsp       rsp_empty, rsp_pop, rsp_data       out        display register write
// csr       csr_write_enable, csr_write_data   in         text width
//
// A load is written to the text store as the engine takes it; a tick steps the scroll
// state and then makes eight display writes, one per read of the single text store
// read port. Reset is synchronous and clears the store at once through per-entry
// valid bits. A full result queue stalls the engine; a busy engine backs up the
// two-entry item queue, which then raises req_full.
module led_matrix_scroll_text #(
   parameter int TEXT_COLUMNS = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  lmst_pkg::req_type req_data,
   output logic              req_full,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output lmst_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic [7:0]        csr_write_data
);
   import lmst_pkg::*;

   logic                   cmd_empty, cmd_pop;
   logic [$bits(req_type)-1:0] cmd_raw;
   req_type                cmd_item;
   logic                   rsp_push;
   rsp_type                rsp_item;
   logic [$bits(rsp_type)-1:0] rsp_raw;
   logic [RSP_LEVEL_W-1:0] rsp_level;

   assign cmd_item = req_type'(cmd_raw);
   assign rsp_data = rsp_type'(rsp_raw);

   lmst_fifo #(
      .WIDTH ($bits(req_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (req_data),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_raw),
      .empty     (cmd_empty),
      .level     ()
   );

   lmst_engine #(
      .TEXT_COLUMNS (TEXT_COLUMNS)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd_empty        (cmd_empty),
      .cmd_item         (cmd_item),
      .cmd_pop          (cmd_pop),
      .rsp_level        (rsp_level),
      .rsp_push         (rsp_push),
      .rsp_item         (rsp_item)
   );

   lmst_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_item),
      .full      (),
      .pop       (rsp_pop),
      .pop_data  (rsp_raw),
      .empty     (rsp_empty),
      .level     (rsp_level)
   );

endmodule

@@ test/scroll_text_checker.sv @@
`timescale 1ns / 1ps

module scroll_text_checker #(
   parameter int TEXT_COLUMNS = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic              req_full,
   input  lmst_pkg::req_type req_data,
   input  logic              rsp_empty,
   input  logic              rsp_pop,
   input  lmst_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic [7:0]        csr_write_data,
   output int                mismatches,
   output int                outstanding
);

   logic [7:0] message_columns [TEXT_COLUMNS];
   logic [7:0] msg_width;
   logic [7:0] win_start;
   logic [7:0] win_span;
   logic [7:0] lead_gap;
   lmst_pkg::rsp_type display_writes [$];

   initial begin
      mismatches = 0;
      outstanding = 0;
   end

   task automatic report(input string what);
      $display("%0t ns mismatch: %s", $time, what);
      mismatches++;
   endtask

   // step the scroll window, then queue the eight register writes of one refresh
   task automatic predict_refresh();
      logic [8:0] reach;
      logic [7:0] pos;
      lmst_pkg::rsp_type w;
      if (lead_gap != 8'd0) begin
         lead_gap--;
         win_span++;
      end else begin
         win_start++;
      end
      if ({1'b0, win_start} + 9'(lmst_pkg::MATRIX_COLUMNS) >= {1'b0, msg_width}) begin
         win_span--;
      end
      if (win_start == msg_width) begin
         win_start = 8'd0;
         win_span = 8'd0;
         lead_gap = 8'(lmst_pkg::MATRIX_COLUMNS);
      end
      reach = {1'b0, win_span} + {1'b0, lead_gap};
      for (int x = 0; x < lmst_pkg::MATRIX_COLUMNS; x++) begin
         w.reg_address = 4'(lmst_pkg::MATRIX_COLUMNS - x);
         w.reg_data = 8'd0;
         if (!(9'(x) > reach || 8'(x) < lead_gap)) begin
            pos = win_start + 8'(x) - lead_gap;
            if (int'(pos) < TEXT_COLUMNS) begin
               w.reg_data = message_columns[pos];
            end
         end
         w.last = (x == lmst_pkg::MATRIX_COLUMNS - 1);
         display_writes.push_back(w);
      end
   endtask

   always @(posedge clock) begin
      lmst_pkg::rsp_type got;
      lmst_pkg::rsp_type want;
      if (reset) begin
         for (int i = 0; i < TEXT_COLUMNS; i++) begin
            message_columns[i] = 8'd0;
         end
         msg_width = lmst_pkg::TEXT_WIDTH_RESET;
         win_start = 8'd0;
         win_span = 8'd0;
         lead_gap = 8'(lmst_pkg::MATRIX_COLUMNS);
         display_writes.delete();
      end else begin
         if (csr_write_enable) begin
            msg_width = csr_write_data;
         end
         if (req_push && !req_full) begin
            if (req_data.cmd == lmst_pkg::CMD_LOAD) begin
               if (int'(req_data.column_index) < TEXT_COLUMNS) begin
                  message_columns[req_data.column_index] = req_data.column_bits;
               end
            end else begin
               predict_refresh();
            end
         end
         if (rsp_pop && !rsp_empty) begin
            got = rsp_data;
            if (display_writes.size() == 0) begin
               report($sformatf("unexpected write addr %0d data %h last %b",
                                got.reg_address, got.reg_data, got.last));
            end else begin
               want = display_writes.pop_front();
               if (got.reg_address != want.reg_address) begin
                  report($sformatf("reg_address %0d, want %0d",
                                   got.reg_address, want.reg_address));
               end
               if (got.reg_data != want.reg_data) begin
                  report($sformatf("reg_data %h, want %h (addr %0d)",
                                   got.reg_data, want.reg_data, want.reg_address));
               end
               if (got.last != want.last) begin
                  report($sformatf("last %b, want %b (addr %0d)",
                                   got.last, want.last, want.reg_address));
               end
            end
         end
      end
      outstanding = display_writes.size();
   end

endmodule

@@ test/tb_led_matrix_scroll_text.sv @@
`timescale 1ns / 1ps

module tb_led_matrix_scroll_text;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 24;
   localparam int PHASE_ITEMS = 56;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_push = 1'b0;
   lmst_pkg::req_type req_data = '0;
   logic              req_full;
   logic              rsp_empty;
   logic              rsp_pop = 1'b0;
   lmst_pkg::rsp_type rsp_data;
   logic              csr_write_enable = 1'b0;
   logic [7:0]        csr_write_data = 8'd0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int cycles = 0;
   int mismatches;
   int outstanding;

   led_matrix_scroll_text uut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_data         (req_data),
      .req_full         (req_full),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   scroll_text_checker watch (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data         (req_data),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("led_matrix_scroll_text regression: fail");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_pop = ($urandom_range(99) >= recv_stall_pct);
   end

   // called at a falling edge; returns at the falling edge after the item is taken
   task automatic send(input lmst_pkg::req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push = 1'b0;
         @(negedge clock);
      end
      req_push = 1'b1;
      req_data = item;
      do @(posedge clock); while (req_full);
      @(negedge clock);
   endtask

   task automatic load_column(input logic [7:0] index, input logic [7:0] bits);
      lmst_pkg::req_type item;
      item.cmd = lmst_pkg::CMD_LOAD;
      item.column_index = index;
      item.column_bits = bits;
      send(item);
   endtask

   task automatic scroll_tick();
      lmst_pkg::req_type item;
      item.cmd = lmst_pkg::CMD_TICK;
      item.column_index = 8'($urandom);
      item.column_bits = 8'($urandom);
      send(item);
   endtask

   task automatic random_item(input int width);
      int hi;
      hi = (width + 8 > 255) ? 255 : width + 8;
      if ($urandom_range(99) < 45) begin
         scroll_tick();
      end else if ($urandom_range(99) < 80) begin
         load_column(8'($urandom_range(hi)), 8'($urandom));
      end else begin
         load_column(8'($urandom), 8'($urandom));
      end
   endtask

   // hold off until every write is out and the engine has gone quiet
   task automatic drain();
      req_push = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_text_width(input logic [7:0] width);
      csr_write_enable = 1'b1;
      csr_write_data = width;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   initial begin : stimulus
      int widths [6];
      int idle_of [4];
      int stall_of [4];
      logic [7:0] patterns [8];
      widths = '{0, 255, 1, 12, 0, 30};
      idle_of = '{0, 66, 0, 33};
      stall_of = '{0, 0, 66, 33};
      patterns = '{8'h01, 8'h80, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'h0F, 8'hF0};
      widths[4] = $urandom_range(254, 2);

      repeat (9) @(negedge clock);
      reset = 1'b0;

      // reset width: fill the message, then a full scroll pass and restart
      for (int i = 0; i < 8; i++) begin
         load_column(8'(i), patterns[i]);
      end
      load_column(8'hFF, 8'hFF);
      repeat (16) scroll_tick();
      drain();

      for (int p = 0; p < 6; p++) begin
         send_idle_pct = idle_of[p % 4];
         recv_stall_pct = stall_of[p % 4];
         set_text_width(8'(widths[p]));
         repeat (PHASE_ITEMS) random_item(widths[p]);
         drain();
      end

      if (mismatches == 0) begin
         $display("led_matrix_scroll_text regression: pass");
      end else begin
         $display("led_matrix_scroll_text regression: fail");
      end
      $finish;
   end

endmodule
